@@ rtl/core/pdqm_pkg.sv @@
package pdqm_pkg;

	localparam int HDR_W   = 8;
	localparam int LEN_W   = 5;
	localparam int RAW_W   = 16;
	localparam int SP_W    = 13;
	localparam int GAIN_W  = 16;
	localparam int MOTOR_W = 10;
	localparam int ERR_W   = 18;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int PP_W    = GAIN_W + 1 + ERR_W;
	localparam int DP_W    = GAIN_W + 1 + DIFF_W;
	localparam int ACC_W   = DP_W;
	localparam int SHIFT   = 12;
	localparam int TERM_W  = 24;
	localparam int MIX_W   = 26;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;

	localparam logic [HDR_W-1:0]   FRAME_HEADER_OK = 8'hBB;
	localparam logic [LEN_W-1:0]   FRAME_MIN_LEN   = 5'd8;
	localparam logic [MOTOR_W-1:0] MOTOR_MAX       = 10'd1023;
	localparam logic [ACC_W-1:0]   DIV_BIAS        = ACC_W'((1 << SHIFT) - 1);

	localparam logic signed [SP_W-1:0] ROLL_SP_RST  = '0;
	localparam logic signed [SP_W-1:0] PITCH_SP_RST = '0;
	localparam logic [GAIN_W-1:0]      PROP_RST     = 16'd1152;
	localparam logic [GAIN_W-1:0]      DERIV_RST    = 16'd384;
	localparam logic [MOTOR_W-1:0]     BASE_RST     = 10'd400;

	typedef enum logic [IDX_W-1:0] {
		REG_ROLL_SP  = 3'd0,
		REG_PITCH_SP = 3'd1,
		REG_PROP     = 3'd2,
		REG_DERIV    = 3'd3,
		REG_BASE     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [SP_W-1:0] roll_setpoint;
		logic signed [SP_W-1:0] pitch_setpoint;
		logic [GAIN_W-1:0]      prop_gain;
		logic [GAIN_W-1:0]      deriv_gain;
		logic [MOTOR_W-1:0]     base_throttle;
	} cfg_t;

	typedef struct packed {
		logic en;    // whole pipeline advances
		logic load;  // a good frame enters stage one
	} pipe_ctl_t;

endpackage

@@ rtl/core/pdqm_if.sv @@
interface pdqm_frame_if import pdqm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [HDR_W-1:0]        frame_header;
	logic [LEN_W-1:0]        frame_length;
	logic signed [RAW_W-1:0] roll_raw;
	logic signed [RAW_W-1:0] pitch_raw;

	modport source (output valid, frame_header, frame_length, roll_raw, pitch_raw,
		input ready);
	modport sink (input valid, frame_header, frame_length, roll_raw, pitch_raw,
		output ready);
endinterface

interface pdqm_motor_if import pdqm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MOTOR_W-1:0] motor_front_left;
	logic [MOTOR_W-1:0] motor_front_right;
	logic [MOTOR_W-1:0] motor_rear_left;
	logic [MOTOR_W-1:0] motor_rear_right;

	modport source (output valid, motor_front_left, motor_front_right, motor_rear_left,
		motor_rear_right, input ready);
	modport sink (input valid, motor_front_left, motor_front_right, motor_rear_left,
		motor_rear_right, output ready);
endinterface

@@ rtl/core/pdqm_cfg_regs.sv @@
module pdqm_cfg_regs import pdqm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_setpoint  <= ROLL_SP_RST;
			cfg_q.pitch_setpoint <= PITCH_SP_RST;
			cfg_q.prop_gain      <= PROP_RST;
			cfg_q.deriv_gain     <= DERIV_RST;
			cfg_q.base_throttle  <= BASE_RST;
		end else if (cfg_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROLL_SP:  cfg_q.roll_setpoint  <= $signed(cfg_data[SP_W-1:0]);
				REG_PITCH_SP: cfg_q.pitch_setpoint <= $signed(cfg_data[SP_W-1:0]);
				REG_PROP:     cfg_q.prop_gain      <= cfg_data[GAIN_W-1:0];
				REG_DERIV:    cfg_q.deriv_gain     <= cfg_data[GAIN_W-1:0];
				REG_BASE:     cfg_q.base_throttle  <= cfg_data[MOTOR_W-1:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/pdqm_axis.sv @@
module pdqm_axis import pdqm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pipe_ctl_t                ctl,
	input  logic signed [SP_W-1:0]   setpoint,
	input  logic signed [RAW_W-1:0]  raw,
	input  logic [GAIN_W-1:0]        prop_gain,
	input  logic [GAIN_W-1:0]        deriv_gain,
	output logic signed [TERM_W-1:0] term
);

	logic signed [ERR_W-1:0]  err;
	logic signed [DIFF_W-1:0] diff;
	logic signed [ERR_W-1:0]  prev_q;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PP_W-1:0]   pp_s2;
	logic signed [DP_W-1:0]   dp_s2;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_adj;
	logic signed [TERM_W-1:0] term_s3;

	assign err  = ERR_W'(setpoint) - ERR_W'(raw);
	assign diff = DIFF_W'(err) - DIFF_W'(prev_q);

	// previous error follows good frames only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctl.load) begin
			prev_q <= err;
		end
	end

	// truncate toward zero: bias negative sums before the shift
	assign acc     = ACC_W'(pp_s2) + dp_s2;
	assign acc_adj = acc[ACC_W-1] ? acc + $signed(DIV_BIAS) : acc;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			err_s1  <= err;
			diff_s1 <= diff;
			pp_s2   <= $signed({1'b0, prop_gain}) * err_s1;
			dp_s2   <= $signed({1'b0, deriv_gain}) * diff_s1;
			term_s3 <= TERM_W'(acc_adj >>> SHIFT);
		end
	end

	assign term = term_s3;

`ifndef SYNTHESIS
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.load |=> $stable(prev_q))
		else $error("previous error changed without a good frame");
	a_prev_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> prev_q == err_s1)
		else $error("previous error and stage one error disagree");
`endif

endmodule

@@ rtl/core/pdqm_mixer.sv @@
module pdqm_mixer import pdqm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pipe_ctl_t                ctl,
	input  logic                     valid_s3,
	input  logic [MOTOR_W-1:0]       base_throttle,
	input  logic signed [TERM_W-1:0] roll_term,
	input  logic signed [TERM_W-1:0] pitch_term,
	pdqm_motor_if.source             motor_out
);

	logic signed [MIX_W-1:0] base_ext;
	logic signed [MIX_W-1:0] tr;
	logic signed [MIX_W-1:0] tp;
	logic signed [MIX_W-1:0] sum_fl;
	logic signed [MIX_W-1:0] sum_fr;
	logic signed [MIX_W-1:0] sum_rl;
	logic signed [MIX_W-1:0] sum_rr;
	logic                    valid_q;
	logic [MOTOR_W-1:0]      fl_q;
	logic [MOTOR_W-1:0]      fr_q;
	logic [MOTOR_W-1:0]      rl_q;
	logic [MOTOR_W-1:0]      rr_q;

	function automatic logic [MOTOR_W-1:0] clamp(input logic signed [MIX_W-1:0] v);
		logic [MOTOR_W-1:0] r;
		if (v[MIX_W-1]) begin
			r = '0;
		end else if (v > $signed(MIX_W'(MOTOR_MAX))) begin
			r = MOTOR_MAX;
		end else begin
			r = v[MOTOR_W-1:0];
		end
		return r;
	endfunction

	assign base_ext = $signed(MIX_W'(base_throttle));
	assign tr       = MIX_W'(roll_term);
	assign tp       = MIX_W'(pitch_term);
	assign sum_fl   = base_ext + tr + tp;
	assign sum_fr   = base_ext - tr + tp;
	assign sum_rl   = base_ext + tr - tp;
	assign sum_rr   = base_ext - tr - tp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.en) begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			fl_q <= clamp(sum_fl);
			fr_q <= clamp(sum_fr);
			rl_q <= clamp(sum_rl);
			rr_q <= clamp(sum_rr);
		end
	end

	assign motor_out.valid             = valid_q;
	assign motor_out.motor_front_left  = fl_q;
	assign motor_out.motor_front_right = fr_q;
	assign motor_out.motor_rear_left   = rl_q;
	assign motor_out.motor_rear_right  = rr_q;

endmodule

@@ rtl/core/pd_attitude_quad_mixer_unit.sv @@
// channel     dir  word                                        handshake
// frame_in    in   header, length, roll_raw, pitch_raw         valid/ready
// motor_out   out  front_left, front_right, rear_left, rear_right  valid/ready
// cfg         in   cfg_en, cfg_index, cfg_data                 write on cfg_en
//
// Four stages: error/difference, gain multiplies, sum and scale, mix and clamp.
// An accepted frame moves through the stage registers in order to motor_out; a new frame
// is taken every cycle unless the output stalls.
// Frames with a bad header or short length are dropped at the input.
// A held result stalls the whole pipeline; ready drops only then.
// Reset clears valid bits and both previous errors and loads the config defaults.
module pd_attitude_quad_mixer_unit import pdqm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	pdqm_frame_if.sink        frame_in,
	pdqm_motor_if.source      motor_out
);

	cfg_t                     cfg;
	pipe_ctl_t                ctl;
	logic                     stall;
	logic                     accept;
	logic                     frame_ok;
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic signed [TERM_W-1:0] roll_term;
	logic signed [TERM_W-1:0] pitch_term;

	assign stall    = motor_out.valid && !motor_out.ready;
	assign frame_ok = (frame_in.frame_header == FRAME_HEADER_OK)
		&& (frame_in.frame_length >= FRAME_MIN_LEN);
	assign frame_in.ready = !stall;
	assign accept   = frame_in.valid && frame_in.ready;
	assign ctl.en   = !stall;
	assign ctl.load = accept && frame_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	pdqm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdqm_axis u_roll (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.setpoint   (cfg.roll_setpoint),
		.raw        (frame_in.roll_raw),
		.prop_gain  (cfg.prop_gain),
		.deriv_gain (cfg.deriv_gain),
		.term       (roll_term)
	);

	pdqm_axis u_pitch (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.setpoint   (cfg.pitch_setpoint),
		.raw        (frame_in.pitch_raw),
		.prop_gain  (cfg.prop_gain),
		.deriv_gain (cfg.deriv_gain),
		.term       (pitch_term)
	);

	pdqm_mixer u_mix (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.valid_s3      (v_s3),
		.base_throttle (cfg.base_throttle),
		.roll_term     (roll_term),
		.pitch_term    (pitch_term),
		.motor_out     (motor_out)
	);

`ifndef SYNTHESIS
	a_drop_bad: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !frame_ok |=> !v_s1)
		else $error("bad frame entered the pipeline");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable({v_s1, v_s2, v_s3}))
		else $error("pipeline moved during output stall");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load ##1 ctl.en ##1 ctl.en ##1 ctl.en |=> motor_out.valid)
		else $error("good frame did not reach the output");
`endif

endmodule

@@ bench/pd_attitude_quad_mixer_unit_tb.sv @@
module pd_attitude_quad_mixer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdqm_pkg::*;

	localparam int     WATCHDOG_LIMIT  = 2000;
	localparam int     SETTLE_CYCLES   = 12;
	localparam int     MAX_REPORTS     = 10;
	localparam int     PHASES_PER_MODE = 4;
	localparam int     ITEMS_PER_PHASE = 135;
	localparam int     SP_SPAN         = 2880;
	localparam int     REG_COUNT       = 5;
	localparam longint DRIVE_SCALE     = longint'(1) << SHIFT;

	localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
	localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};

	typedef struct packed {
		logic [HDR_W-1:0]        header;
		logic [LEN_W-1:0]        length;
		logic signed [RAW_W-1:0] roll;
		logic signed [RAW_W-1:0] pitch;
	} frame_t;

	typedef struct packed {
		logic [MOTOR_W-1:0] front_left;
		logic [MOTOR_W-1:0] front_right;
		logic [MOTOR_W-1:0] rear_left;
		logic [MOTOR_W-1:0] rear_right;
	} motor_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_en;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;

	pdqm_frame_if frame_in ();
	pdqm_motor_if motor_out ();

	pd_attitude_quad_mixer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame_in  (frame_in),
		.motor_out (motor_out)
	);

	// controller state as the block should hold it
	logic signed [SP_W-1:0]  sp_roll;
	logic signed [SP_W-1:0]  sp_pitch;
	logic [GAIN_W-1:0]       kp;
	logic [GAIN_W-1:0]       kd;
	logic [MOTOR_W-1:0]      base;
	logic signed [ERR_W-1:0] prev_roll_err;
	logic signed [ERR_W-1:0] prev_pitch_err;
	logic signed [RAW_W-1:0] walk_roll;
	logic signed [RAW_W-1:0] walk_pitch;

	motor_word_t motor_words_due[$];

	int send_idle_pct = 14;
	int recv_idle_pct = 46;
	int fail_count    = 0;
	int frames_sent   = 0;
	int frames_good   = 0;
	int words_checked = 0;
	int phases_run    = 0;
	int stall_cycles  = 0;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void log_fail(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%t  %s", $realtime, msg);
	endfunction

	function automatic longint pd_drive(longint err, longint prev_err);
		return (longint'(kp) * err + longint'(kd) * (err - prev_err)) / DRIVE_SCALE;
	endfunction

	function automatic logic [MOTOR_W-1:0] clamp_motor(longint v);
		if (v > longint'(MOTOR_MAX))
			return MOTOR_MAX;
		if (v < 0)
			return '0;
		return v[MOTOR_W-1:0];
	endfunction

	function automatic void predict_motors(frame_t f);
		longint      err_r, err_p, drv_r, drv_p, b;
		motor_word_t w;
		// drop short or misheaded frames, state untouched
		if (f.length < FRAME_MIN_LEN || f.header != FRAME_HEADER_OK)
			return;
		err_r = longint'(sp_roll) - longint'($signed(f.roll));
		err_p = longint'(sp_pitch) - longint'($signed(f.pitch));
		drv_r = pd_drive(err_r, longint'(prev_roll_err));
		drv_p = pd_drive(err_p, longint'(prev_pitch_err));
		prev_roll_err  = err_r[ERR_W-1:0];
		prev_pitch_err = err_p[ERR_W-1:0];
		b = longint'(base);
		w.front_left  = clamp_motor(b + drv_r + drv_p);
		w.front_right = clamp_motor(b - drv_r + drv_p);
		w.rear_left   = clamp_motor(b + drv_r - drv_p);
		w.rear_right  = clamp_motor(b - drv_r - drv_p);
		motor_words_due.push_back(w);
		frames_good++;
	endfunction

	function automatic void check_word();
		motor_word_t got, exp;
		got = '{motor_out.motor_front_left, motor_out.motor_front_right,
			motor_out.motor_rear_left, motor_out.motor_rear_right};
		words_checked++;
		if (motor_words_due.size() == 0) begin
			log_fail($sformatf("unexpected motor word fl=%0d fr=%0d rl=%0d rr=%0d",
				got.front_left, got.front_right, got.rear_left, got.rear_right));
			return;
		end
		exp = motor_words_due.pop_front();
		if (got.front_left !== exp.front_left || got.front_right !== exp.front_right ||
			got.rear_left !== exp.rear_left || got.rear_right !== exp.rear_right)
			log_fail($sformatf({"motor word %0d: expected fl=%0d fr=%0d rl=%0d rr=%0d,",
				" got fl=%0d fr=%0d rl=%0d rr=%0d"}, words_checked,
				exp.front_left, exp.front_right, exp.rear_left, exp.rear_right,
				got.front_left, got.front_right, got.rear_left, got.rear_right));
	endfunction

	// sample at the falling edge: valid, ready and the word are stable there
	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if ((frame_in.valid === 1'b1 && frame_in.ready === 1'b1) ||
				(motor_out.valid === 1'b1 && motor_out.ready === 1'b1))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (motor_out.valid === 1'b1 && motor_out.ready === 1'b1)
				check_word();
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (stall_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("Watchdog: no handshake for %0d cycles, %0d words outstanding",
			stall_cycles, motor_words_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		motor_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			motor_out.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_frame(input frame_t f);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid        <= 1'b1;
		frame_in.frame_header <= f.header;
		frame_in.frame_length <= f.length;
		frame_in.roll_raw     <= f.roll;
		frame_in.pitch_raw    <= f.pitch;
		do @(negedge clk); while (frame_in.ready !== 1'b1);
		@(posedge clk);
		frames_sent++;
		predict_motors(f);
	endtask

	// drop valid, drain the pipeline, then give dropped frames time to clear
	task automatic settle();
		frame_in.valid <= 1'b0;
		while (motor_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_en <= 1'b0;
		case (idx)
			REG_ROLL_SP:  sp_roll  = data[SP_W-1:0];
			REG_PITCH_SP: sp_pitch = data[SP_W-1:0];
			REG_PROP:     kp       = data[GAIN_W-1:0];
			REG_DERIV:    kd       = data[GAIN_W-1:0];
			REG_BASE:     base     = data[MOTOR_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [DATA_W-1:0] pick_setpoint();
		case ($urandom_range(9))
			0: return DATA_W'(SP_SPAN);
			1: return DATA_W'(-SP_SPAN);
			2: return DATA_W'($urandom);
			default: return DATA_W'(int'($urandom_range(2 * SP_SPAN)) - SP_SPAN);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return DATA_W'($urandom);
			default: return DATA_W'($urandom_range(2047));
		endcase
	endfunction

	function automatic logic signed [RAW_W-1:0] pick_angle(int kind,
		logic signed [RAW_W-1:0] walk);
		if (kind < 2)
			return RAW_W'($urandom);
		if (kind < 6)
			return walk + RAW_W'(int'($urandom_range(64)) - 32);
		return RAW_W'(int'($urandom_range(6000)) - 3000);
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int     kind;
		f.header = FRAME_HEADER_OK;
		f.length = LEN_W'($urandom_range(31, FRAME_MIN_LEN));
		if ($urandom_range(99) >= 85) begin
			if ($urandom_range(1))
				f.length = LEN_W'($urandom_range(FRAME_MIN_LEN - 1, 0));
			else
				do f.header = HDR_W'($urandom); while (f.header == FRAME_HEADER_OK);
		end
		kind       = $urandom_range(9);
		walk_roll  = pick_angle(kind, walk_roll);
		walk_pitch = pick_angle(kind, walk_pitch);
		f.roll     = walk_roll;
		f.pitch    = walk_pitch;
		return f;
	endfunction

	task automatic randomize_registers();
		logic [DATA_W-1:0] b;
		case ($urandom_range(9))
			0: b = '0;
			1: b = DATA_W'(MOTOR_MAX);
			default: b = DATA_W'($urandom_range(MOTOR_MAX));
		endcase
		write_reg(REG_ROLL_SP, pick_setpoint());
		write_reg(REG_PITCH_SP, pick_setpoint());
		write_reg(REG_PROP, pick_gain());
		write_reg(REG_DERIV, pick_gain());
		write_reg(REG_BASE, b);
		phases_run++;
	endtask

	task automatic test_reset_config();
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, 16'sd0, 16'sd0});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, 16'sd320, -16'sd320});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, -16'sd16, 16'sd48});
	endtask

	task automatic test_frame_filter();
		send_frame('{FRAME_HEADER_OK ^ 8'h01, FRAME_MIN_LEN, 16'sd100, 16'sd100});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN - 5'd1, 16'sd200, -16'sd200});
		send_frame('{'0, '0, RAW_MAX, RAW_MIN});
		send_frame('{'1, '1, RAW_MIN, RAW_MAX});
		send_frame('{~FRAME_HEADER_OK, FRAME_MIN_LEN, 16'sd50, 16'sd50});
		// these two must see the previous errors of the last good frame
		send_frame('{FRAME_HEADER_OK, '1, 16'sd64, 16'sd32});
		send_frame('{FRAME_HEADER_OK, LEN_W'(30), -16'sd64, -16'sd32});
	endtask

	task automatic test_angle_extremes();
		settle();
		write_reg(REG_ROLL_SP, DATA_W'(SP_SPAN));
		write_reg(REG_PITCH_SP, DATA_W'(-SP_SPAN));
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MIN, RAW_MAX});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MAX, RAW_MIN});
		settle();
		// setpoints beyond the nominal span, at the limits of the signed 13-bit value
		write_reg(REG_ROLL_SP, 16'h0FFF);
		write_reg(REG_PITCH_SP, 16'hF000);
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MIN, RAW_MIN});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MAX, RAW_MAX});
	endtask

	task automatic test_gain_extremes();
		settle();
		write_reg(REG_PROP, '0);
		write_reg(REG_DERIV, '0);
		write_reg(REG_BASE, '0);
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MAX, RAW_MIN});
		settle();
		write_reg(REG_BASE, DATA_W'(MOTOR_MAX));
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MIN, RAW_MAX});
		settle();
		write_reg(REG_PROP, '1);
		write_reg(REG_DERIV, '1);
		write_reg(REG_BASE, DATA_W'(MOTOR_MAX / 2));
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MAX, RAW_MIN});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, RAW_MIN, RAW_MAX});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, 16'sd0, 16'sd0});
	endtask

	task automatic test_unknown_index();
		settle();
		write_reg(REG_PROP, DATA_W'(PROP_RST));
		write_reg(REG_DERIV, DATA_W'(DERIV_RST));
		for (int i = REG_COUNT; i < (1 << IDX_W); i++)
			write_reg(IDX_W'(i), DATA_W'($urandom));
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, 16'sd480, -16'sd96});
		send_frame('{FRAME_HEADER_OK, FRAME_MIN_LEN, -16'sd480, 16'sd96});
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (PHASES_PER_MODE) begin
			settle();
			randomize_registers();
			repeat (ITEMS_PER_PHASE)
				send_frame(random_frame());
		end
	endtask

	initial begin
		sp_roll        = ROLL_SP_RST;
		sp_pitch       = PITCH_SP_RST;
		kp             = PROP_RST;
		kd             = DERIV_RST;
		base           = BASE_RST;
		prev_roll_err  = '0;
		prev_pitch_err = '0;
		walk_roll      = '0;
		walk_pitch     = '0;

		arst_n                <= 1'b0;
		cfg_en                <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		frame_in.valid        <= 1'b0;
		frame_in.frame_header <= '0;
		frame_in.frame_length <= '0;
		frame_in.roll_raw     <= '0;
		frame_in.pitch_raw    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_config();
		test_frame_filter();
		test_angle_extremes();
		test_gain_extremes();
		test_unknown_index();
		test_random_traffic(14, 46);
		test_random_traffic(46, 14);
		test_random_traffic(0, 0);
		settle();

		if (motor_words_due.size() != 0)
			log_fail($sformatf("%0d motor words never arrived", motor_words_due.size()));
		$display("Sent %0d frames (%0d well-formed) across %0d random register settings;",
			frames_sent, frames_good, phases_run);
		$display("checked %0d motor words under three idle mixes, %0d problems found",
			words_checked, fail_count);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
